// ===== rtl/core/sbe_pkg.sv =====
// ----------------------------------------------------------------------------
// sbe_pkg
// Types, opcodes, status codes and decode tables for the bytecode execute unit.
// ----------------------------------------------------------------------------
package sbe_pkg;

    localparam int unsigned STACK_DEPTH_DEF = 64;
    localparam int unsigned LOCAL_COUNT_DEF = 256;
    localparam int unsigned PC_BITS_DEF     = 16;

    localparam logic [4:0] OP_POP    = 5'd0;
    localparam logic [4:0] OP_DUP    = 5'd1;
    localparam logic [4:0] OP_SWAP   = 5'd2;
    localparam logic [4:0] OP_ADD    = 5'd3;
    localparam logic [4:0] OP_SUB    = 5'd4;
    localparam logic [4:0] OP_MUL    = 5'd5;
    localparam logic [4:0] OP_DIV    = 5'd6;
    localparam logic [4:0] OP_REM    = 5'd7;
    localparam logic [4:0] OP_AND    = 5'd8;
    localparam logic [4:0] OP_OR     = 5'd9;
    localparam logic [4:0] OP_XOR    = 5'd10;
    localparam logic [4:0] OP_SHL    = 5'd11;
    localparam logic [4:0] OP_SHR    = 5'd12;
    localparam logic [4:0] OP_BIPUSH = 5'd13;
    localparam logic [4:0] OP_LDC    = 5'd14;
    localparam logic [4:0] OP_NULL   = 5'd15;
    localparam logic [4:0] OP_VLOAD  = 5'd16;
    localparam logic [4:0] OP_VSTORE = 5'd17;
    localparam logic [4:0] OP_NOP    = 5'd18;
    localparam logic [4:0] OP_CMPEQ  = 5'd19;
    localparam logic [4:0] OP_CMPNE  = 5'd20;
    localparam logic [4:0] OP_CMPLT  = 5'd21;
    localparam logic [4:0] OP_CMPGE  = 5'd22;
    localparam logic [4:0] OP_CMPGT  = 5'd23;
    localparam logic [4:0] OP_CMPLE  = 5'd24;
    localparam logic [4:0] OP_GOTO   = 5'd25;
    localparam logic [4:0] OP_ATHROW = 5'd26;
    localparam logic [4:0] OP_ASSERT = 5'd27;
    localparam logic [4:0] OP_RETURN = 5'd28;

    localparam logic [3:0] ST_OK     = 4'd0;
    localparam logic [3:0] ST_RET    = 4'd1;
    localparam logic [3:0] ST_DIV0   = 4'd2;
    localparam logic [3:0] ST_DIVOVF = 4'd3;
    localparam logic [3:0] ST_SHIFT  = 4'd4;
    localparam logic [3:0] ST_ASSERT = 4'd5;
    localparam logic [3:0] ST_UNDER  = 4'd6;
    localparam logic [3:0] ST_OVER   = 4'd7;
    localparam logic [3:0] ST_THROW  = 4'd8;

    typedef struct packed {
        logic [4:0]         action;
        logic signed [31:0] immediate;
        logic [7:0]         local_index;
        logic signed [15:0] branch_offset;
    } t_in;

    typedef struct packed {
        logic [15:0]        next_pc;
        logic signed [31:0] top_value;
        logic [6:0]         stack_depth;
        logic [3:0]         status;
    } t_out;

    function automatic logic [1:0] need_words(input logic [4:0] op);
        logic [1:0] n;
        case (op)
            OP_POP, OP_DUP, OP_VSTORE, OP_ATHROW, OP_RETURN: n = 2'd1;
            OP_BIPUSH, OP_LDC, OP_NULL, OP_VLOAD, OP_NOP, OP_GOTO: n = 2'd0;
            default: n = (op <= OP_ASSERT) ? 2'd2 : 2'd0;
        endcase
        return n;
    endfunction

    function automatic logic grows(input logic [4:0] op);
        logic g;
        case (op)
            OP_DUP, OP_BIPUSH, OP_LDC, OP_NULL, OP_VLOAD: g = 1'b1;
            default: g = 1'b0;
        endcase
        return g;
    endfunction

endpackage

// ===== rtl/core/sbe_ram.sv =====
// ----------------------------------------------------------------------------
// sbe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbe_ram #(
    parameter int unsigned WIDTH  = 32,
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/stack_bytecode_execute_unit.sv =====
// ----------------------------------------------------------------------------
// stack_bytecode_execute_unit
// Execute one decoded stack-machine instruction per transfer.
// Operands are read serially through the single stack RAM read port (S_RDB, S_RDA,
// S_RDC, S_LOC) before S_EXEC; swap adds a second write in S_WR, and divide and
// remainder pass through S_DIV, a radix-2 divider that runs one quotient bit a cycle,
// then S_FIX. A new instruction is accepted only after the result is taken from S_OUT.
// Reset clears pc, stack pointer and halt state; stack and locals are unset.
// ----------------------------------------------------------------------------
module stack_bytecode_execute_unit #(
    parameter int unsigned STACK_DEPTH = sbe_pkg::STACK_DEPTH_DEF,
    parameter int unsigned LOCAL_COUNT = sbe_pkg::LOCAL_COUNT_DEF,
    parameter int unsigned PC_BITS     = sbe_pkg::PC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sbe_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output sbe_pkg::t_out o_out_data
);

    localparam int unsigned SP_W = $clog2(STACK_DEPTH + 1);
    localparam int unsigned AW   = $clog2(STACK_DEPTH);
    localparam int unsigned LA_W = (LOCAL_COUNT > 1) ? $clog2(LOCAL_COUNT) : 1;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_RDB  = 10'b00_0000_0010,
        S_RDA  = 10'b00_0000_0100,
        S_RDC  = 10'b00_0000_1000,
        S_LOC  = 10'b00_0001_0000,
        S_EXEC = 10'b00_0010_0000,
        S_DIV  = 10'b00_0100_0000,
        S_FIX  = 10'b00_1000_0000,
        S_WR   = 10'b01_0000_0000,
        S_OUT  = 10'b10_0000_0000
    } t_state;

    t_state            r_state, n_state;
    sbe_pkg::t_in      r_in, n_in;
    sbe_pkg::t_out     r_out, n_out;
    logic [31:0]       r_a, n_a, r_b, n_b, r_c, n_c;
    logic [PC_BITS-1:0] r_pc, n_pc;
    logic [SP_W-1:0]   r_sp, n_sp;
    logic              r_halt, n_halt;
    logic [3:0]        r_hst, n_hst;
    logic [31:0]       r_quo, n_quo, r_rem, n_rem, r_dvs, n_dvs;
    logic [4:0]        r_cnt, n_cnt;
    logic              r_neg_q, n_neg_q, r_neg_r, n_neg_r, r_is_rem, n_is_rem;

    logic              st_we;
    logic [AW-1:0]     st_waddr, st_raddr;
    logic [31:0]       st_wdata, st_rdata;
    logic              lc_we;
    logic [LA_W-1:0]   lc_addr;
    logic [31:0]       lc_rdata;

    logic [31:0]       a_v, b_v, c_v, alu, a_mag, b_mag, q_fix, r_fix, psh;
    logic [32:0]       rem_sh, diff;
    logic [PC_BITS-1:0] target;
    logic              idx_ok, take;

    sbe_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk  (i_clk),
        .i_we   (st_we),
        .i_waddr(st_waddr),
        .i_wdata(st_wdata),
        .i_raddr(st_raddr),
        .o_rdata(st_rdata)
    );

    sbe_ram #(.WIDTH(32), .DEPTH(LOCAL_COUNT)) u_locals (
        .i_clk  (i_clk),
        .i_we   (lc_we),
        .i_waddr(lc_addr),
        .i_wdata(b_v),
        .i_raddr(lc_addr),
        .o_rdata(lc_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data  = r_out;

    assign a_v    = (r_sp >= SP_W'(2)) ? r_a : 32'd0;
    assign b_v    = (r_sp >= SP_W'(1)) ? r_b : 32'd0;
    assign c_v    = (r_sp >= SP_W'(3)) ? r_c : 32'd0;
    assign a_mag  = a_v[31] ? (32'd0 - a_v) : a_v;
    assign b_mag  = b_v[31] ? (32'd0 - b_v) : b_v;
    assign idx_ok = ({1'b0, r_in.local_index} < 9'(LOCAL_COUNT));
    assign lc_addr = LA_W'(r_in.local_index);
    assign target = r_pc + PC_BITS'(r_in.branch_offset);
    assign rem_sh = {r_rem, r_quo[31]};
    assign diff   = rem_sh - {1'b0, r_dvs};
    assign q_fix  = r_neg_q ? (32'd0 - r_quo) : r_quo;
    assign r_fix  = r_neg_r ? (32'd0 - r_rem) : r_rem;

    always_comb begin
        case (r_state)
            S_RDA:   st_raddr = AW'(r_sp - SP_W'(2));
            S_RDC:   st_raddr = AW'(r_sp - SP_W'(3));
            default: st_raddr = AW'(r_sp - SP_W'(1));
        endcase
    end

    always_comb begin
        case (r_in.action)
            sbe_pkg::OP_ADD: alu = a_v + b_v;
            sbe_pkg::OP_SUB: alu = a_v - b_v;
            sbe_pkg::OP_MUL: alu = a_v * b_v;
            sbe_pkg::OP_AND: alu = a_v & b_v;
            sbe_pkg::OP_OR:  alu = a_v | b_v;
            sbe_pkg::OP_XOR: alu = a_v ^ b_v;
            sbe_pkg::OP_SHL: alu = a_v << b_v[4:0];
            default:         alu = 32'($signed(a_v) >>> b_v[4:0]);
        endcase
        case (r_in.action)
            sbe_pkg::OP_CMPEQ: take = (a_v == b_v);
            sbe_pkg::OP_CMPNE: take = (a_v != b_v);
            sbe_pkg::OP_CMPLT: take = ($signed(a_v) < $signed(b_v));
            sbe_pkg::OP_CMPGE: take = ($signed(a_v) >= $signed(b_v));
            sbe_pkg::OP_CMPGT: take = ($signed(a_v) > $signed(b_v));
            default:           take = ($signed(a_v) <= $signed(b_v));
        endcase
        case (r_in.action)
            sbe_pkg::OP_BIPUSH: psh = 32'($signed(r_in.immediate[7:0]));
            sbe_pkg::OP_LDC:    psh = r_in.immediate;
            sbe_pkg::OP_VLOAD:  psh = idx_ok ? lc_rdata : 32'd0;
            sbe_pkg::OP_DUP:    psh = b_v;
            default:            psh = 32'd0;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_in     = r_in;
        n_out    = r_out;
        n_a      = r_a;
        n_b      = r_b;
        n_c      = r_c;
        n_pc     = r_pc;
        n_sp     = r_sp;
        n_halt   = r_halt;
        n_hst    = r_hst;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_dvs    = r_dvs;
        n_cnt    = r_cnt;
        n_neg_q  = r_neg_q;
        n_neg_r  = r_neg_r;
        n_is_rem = r_is_rem;
        st_we    = 1'b0;
        st_waddr = AW'(r_sp - SP_W'(2));
        st_wdata = b_v;
        lc_we    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_data;
                    n_state = S_RDB;
                end
            end
            S_RDB: n_state = S_RDA;
            S_RDA: begin
                n_b     = st_rdata;
                n_state = S_RDC;
            end
            S_RDC: begin
                n_a     = st_rdata;
                n_state = S_LOC;
            end
            S_LOC: begin
                n_c     = st_rdata;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_OUT;
                n_out   = '{16'(r_pc), b_v, 7'(r_sp), sbe_pkg::ST_OK};
                if (r_halt) begin
                    n_out.status = r_hst;
                end else if (r_sp < SP_W'(sbe_pkg::need_words(r_in.action))) begin
                    n_halt = 1'b1;
                    n_hst  = sbe_pkg::ST_UNDER;
                    n_out.status = sbe_pkg::ST_UNDER;
                end else if (sbe_pkg::grows(r_in.action) && r_sp >= SP_W'(STACK_DEPTH)) begin
                    n_halt = 1'b1;
                    n_hst  = sbe_pkg::ST_OVER;
                    n_out.status = sbe_pkg::ST_OVER;
                end else begin
                    case (r_in.action)
                        sbe_pkg::OP_ADD, sbe_pkg::OP_SUB, sbe_pkg::OP_MUL,
                        sbe_pkg::OP_AND, sbe_pkg::OP_OR, sbe_pkg::OP_XOR,
                        sbe_pkg::OP_SHL, sbe_pkg::OP_SHR: begin
                            if ((r_in.action == sbe_pkg::OP_SHL
                                 || r_in.action == sbe_pkg::OP_SHR) && b_v > 32'd31) begin
                                n_halt = 1'b1;
                                n_hst  = sbe_pkg::ST_SHIFT;
                                n_out.status = sbe_pkg::ST_SHIFT;
                            end else begin
                                st_we = 1'b1;
                                st_wdata = alu;
                                n_sp  = r_sp - SP_W'(1);
                                n_pc  = r_pc + PC_BITS'(1);
                                n_out = '{16'(n_pc), alu, 7'(n_sp), sbe_pkg::ST_OK};
                            end
                        end
                        sbe_pkg::OP_DIV, sbe_pkg::OP_REM: begin
                            if (b_v == 32'd0) begin
                                n_halt = 1'b1;
                                n_hst  = sbe_pkg::ST_DIV0;
                                n_out.status = sbe_pkg::ST_DIV0;
                            end else if (a_v == 32'h8000_0000 && b_v == 32'hFFFF_FFFF) begin
                                n_halt = 1'b1;
                                n_hst  = sbe_pkg::ST_DIVOVF;
                                n_out.status = sbe_pkg::ST_DIVOVF;
                            end else begin
                                n_quo    = a_mag;
                                n_rem    = 32'd0;
                                n_dvs    = b_mag;
                                n_cnt    = 5'd0;
                                n_neg_q  = a_v[31] ^ b_v[31];
                                n_neg_r  = a_v[31];
                                n_is_rem = (r_in.action == sbe_pkg::OP_REM);
                                n_state  = S_DIV;
                            end
                        end
                        sbe_pkg::OP_CMPEQ, sbe_pkg::OP_CMPNE, sbe_pkg::OP_CMPLT,
                        sbe_pkg::OP_CMPGE, sbe_pkg::OP_CMPGT, sbe_pkg::OP_CMPLE: begin
                            n_sp  = r_sp - SP_W'(2);
                            n_pc  = take ? target : r_pc + PC_BITS'(3);
                            n_out = '{16'(n_pc), c_v, 7'(n_sp), sbe_pkg::ST_OK};
                        end
                        sbe_pkg::OP_POP: begin
                            n_sp  = r_sp - SP_W'(1);
                            n_pc  = r_pc + PC_BITS'(1);
                            n_out = '{16'(n_pc), a_v, 7'(n_sp), sbe_pkg::ST_OK};
                        end
                        sbe_pkg::OP_SWAP: begin
                            st_we   = 1'b1;
                            n_pc    = r_pc + PC_BITS'(1);
                            n_out   = '{16'(n_pc), a_v, 7'(r_sp), sbe_pkg::ST_OK};
                            n_state = S_WR;
                        end
                        sbe_pkg::OP_DUP, sbe_pkg::OP_BIPUSH, sbe_pkg::OP_LDC,
                        sbe_pkg::OP_NULL, sbe_pkg::OP_VLOAD: begin
                            st_we    = 1'b1;
                            st_waddr = AW'(r_sp);
                            st_wdata = psh;
                            n_sp     = r_sp + SP_W'(1);
                            case (r_in.action)
                                sbe_pkg::OP_BIPUSH, sbe_pkg::OP_VLOAD:
                                    n_pc = r_pc + PC_BITS'(2);
                                sbe_pkg::OP_LDC: n_pc = r_pc + PC_BITS'(3);
                                default:         n_pc = r_pc + PC_BITS'(1);
                            endcase
                            n_out = '{16'(n_pc), psh, 7'(n_sp), sbe_pkg::ST_OK};
                        end
                        sbe_pkg::OP_VSTORE: begin
                            lc_we = idx_ok;
                            n_sp  = r_sp - SP_W'(1);
                            n_pc  = r_pc + PC_BITS'(2);
                            n_out = '{16'(n_pc), a_v, 7'(n_sp), sbe_pkg::ST_OK};
                        end
                        sbe_pkg::OP_GOTO: begin
                            n_pc = target;
                            n_out.next_pc = 16'(target);
                        end
                        sbe_pkg::OP_ATHROW: begin
                            n_halt = 1'b1;
                            n_hst  = sbe_pkg::ST_THROW;
                            n_out.status = sbe_pkg::ST_THROW;
                        end
                        sbe_pkg::OP_ASSERT: begin
                            if (a_v == 32'd0) begin
                                n_halt = 1'b1;
                                n_hst  = sbe_pkg::ST_ASSERT;
                                n_out.status = sbe_pkg::ST_ASSERT;
                            end else begin
                                n_sp  = r_sp - SP_W'(2);
                                n_pc  = r_pc + PC_BITS'(1);
                                n_out = '{16'(n_pc), c_v, 7'(n_sp), sbe_pkg::ST_OK};
                            end
                        end
                        sbe_pkg::OP_RETURN: begin
                            n_sp   = r_sp - SP_W'(1);
                            n_halt = 1'b1;
                            n_hst  = sbe_pkg::ST_RET;
                            n_out  = '{16'(r_pc), b_v, 7'(n_sp), sbe_pkg::ST_RET};
                        end
                        default: begin
                            n_pc = r_pc + PC_BITS'(1);
                            n_out.next_pc = 16'(n_pc);
                        end
                    endcase
                end
            end
            S_DIV: begin
                n_quo = {r_quo[30:0], ~diff[32]};
                n_rem = diff[32] ? rem_sh[31:0] : diff[31:0];
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                st_we    = 1'b1;
                st_wdata = r_is_rem ? r_fix : q_fix;
                n_sp     = r_sp - SP_W'(1);
                n_pc     = r_pc + PC_BITS'(1);
                n_out    = '{16'(n_pc), st_wdata, 7'(n_sp), sbe_pkg::ST_OK};
                n_state  = S_OUT;
            end
            S_WR: begin
                st_we    = 1'b1;
                st_waddr = AW'(r_sp - SP_W'(1));
                st_wdata = a_v;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_sp    <= '0;
            r_halt  <= 1'b0;
            r_hst   <= sbe_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_sp    <= n_sp;
            r_halt  <= n_halt;
            r_hst   <= n_hst;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in     <= n_in;
        r_out    <= n_out;
        r_a      <= n_a;
        r_b      <= n_b;
        r_c      <= n_c;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_dvs    <= n_dvs;
        r_cnt    <= n_cnt;
        r_neg_q  <= n_neg_q;
        r_neg_r  <= n_neg_r;
        r_is_rem <= n_is_rem;
    end

endmodule

// ===== rtl/core/sbe_checker.sv =====
// ----------------------------------------------------------------------------
// sbe_checker
// Port-level checks on the execute unit handshake sequencing.
// ----------------------------------------------------------------------------
module sbe_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input sbe_pkg::t_out o_out_data
);

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while result pending");

    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (!o_in_ready && !o_out_valid))
        else $error("result or ready right after input transfer");

    a_out_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |=> (o_in_ready && !o_out_valid))
        else $error("not idle after result transfer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result dropped or changed");

endmodule

bind stack_bytecode_execute_unit sbe_checker u_sbe_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);
